[hdl/obpe_pkg.sv]
`timescale 1ns / 1ps
// package: sizes, register codes and shared types of the obstacle boundary point extractor
package obpe_pkg;

  // map size limits and the widths that follow from them
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ROWC_W     = ROW_W + 1;
  localparam int IDX_W      = (COL_W > ROW_W) ? COL_W : ROW_W;

  // field and register widths
  localparam int CFG_DIM_W  = 11;
  localparam int THR_W      = 8;
  localparam int STEP_W     = 10;
  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 24;
  localparam int PROD_W     = IDX_W + SIZE_W;
  localparam int SUM_W      = ((PROD_W > COORD_W) ? PROD_W : COORD_W) + 2;
  localparam int VALUE_W    = 8;
  localparam int OUT_IDX_W  = 10;

  // port widths
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // register reset values
  localparam logic [CFG_DIM_W-1:0]      RST_MAP_WIDTH  = 11'd1024;
  localparam logic [CFG_DIM_W-1:0]      RST_MAP_HEIGHT = 11'd1024;
  localparam logic signed [THR_W-1:0]   RST_THRESHOLD  = 8'sd1;
  localparam logic [STEP_W-1:0]         RST_GRID_STEP  = 10'd20;
  localparam logic signed [COORD_W-1:0] RST_ORIGIN     = '0;
  localparam logic [SIZE_W-1:0]         RST_CELL_SIZE  = 24'd3277;

  // saturation limits of a coordinate
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAP_WIDTH      = 3'd0,
    CFG_MAP_HEIGHT     = 3'd1,
    CFG_OBST_THRESHOLD = 3'd2,
    CFG_GRID_STEP      = 3'd3,
    CFG_ORIGIN_X       = 3'd4,
    CFG_ORIGIN_Y       = 3'd5,
    CFG_CELL_SIZE      = 3'd6
  } cfg_reg_t;

  // window fetch sequencer
  typedef enum logic [1:0] {
    ST_FETCH_A,
    ST_FETCH_B,
    ST_RUN
  } fetch_state_t;

  // free bits of one column: row above the decided row, and the decided row
  typedef struct packed {
    logic upper;
    logic center;
  } free_pair_t;

  // control of one window cell
  typedef struct packed {
    logic en;
    logic load_ext;
  } cell_ctrl_t;

  // one finished result
  typedef struct packed {
    logic                        keep;
    logic                        done;
    logic [OUT_IDX_W-1:0]        col;
    logic [OUT_IDX_W-1:0]        row;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
  } result_t;

endpackage

[hdl/obpe_cell.sv]
`timescale 1ns / 1ps
// window cell: holds the free bits of one column of the previous rows and passes them on
module obpe_cell import obpe_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  free_pair_t ext_word,
  input  free_pair_t nbr_word,
  output free_pair_t word
);

  free_pair_t word_r;
  free_pair_t word_nxt;

  // shift from the neighbor, or take a freshly written column
  always_comb begin
    word_nxt = word_r;
    if (ctrl.en) begin
      if (ctrl.load_ext) begin
        word_nxt = ext_word;
      end else begin
        word_nxt = nbr_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

[hdl/obpe_coord.sv]
`timescale 1ns / 1ps
// coordinate unit: origin plus index times cell size, saturated to q16.16, two stages
module obpe_coord import obpe_pkg::*; (
  input  logic                      clk,
  input  logic [IDX_W-1:0]          idx,
  input  logic                      zero,
  input  logic signed [COORD_W-1:0] origin,
  input  logic [SIZE_W-1:0]         cell_size,
  output logic signed [COORD_W-1:0] point
);

  logic [PROD_W-1:0]         prod_r;
  logic                      zero_r;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-COORD_W:0]    sum_hi;
  logic signed [COORD_W-1:0] sat;
  logic signed [COORD_W-1:0] point_r;

  // stage one: product
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(idx) * PROD_W'(cell_size);
    zero_r <= zero;
  end

  // exact sum, clipped to the signed 32 bit range
  always_comb begin
    sum    = $signed(SUM_W'(origin)) + $signed(SUM_W'(prod_r));
    sum_hi = sum[SUM_W-1:COORD_W-1];
    if ((&sum_hi) || !(|sum_hi)) begin
      sat = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = COORD_MIN;
    end else begin
      sat = COORD_MAX;
    end
  end

  // stage two: result, zero for an undecided cell
  always_ff @(posedge clk) begin
    point_r <= zero_r ? '0 : sat;
  end

  assign point = point_r;

endmodule

[hdl/occupancy_boundary_point_extract_core.sv]
`timescale 1ns / 1ps
// top level: obstacle boundary point extractor over a raster-order occupancy stream
//
// Takes one occupancy cell per clock in raster order while in_tready is high and
// returns one result per cell, decided one row behind the input: the result names the
// cell one row up, says whether it is a kept obstacle boundary point (out_tuser) and
// gives its indices and its q16.16 coordinates; a padding row closes each frame and its
// last cell carries out_tlast. Sustained rate is one cell per cycle while in_tready is
// high, set by the column line buffer, which takes one write and one read each cycle,
// and by a two-cell window that slides along the row. Up to eight results queue at the
// output while the downstream side stalls, with input accepted while fewer than eight
// are outstanding. After reset and after every write of map_width the window is refilled
// from the line buffer in ST_FETCH_A and ST_FETCH_B, during which in_tready stays low.
module occupancy_boundary_point_extract_core import obpe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input cells
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] cell_value
  input  logic                   in_tuser,   // [0] pad_row
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] cell_col, [19:10] cell_row,
                                             // [51:20] point_x, [83:52] point_y
  output logic                   out_tuser,  // [0] keep_point
  output logic                   out_tlast,  // frame_done
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [CFG_DIM_W-1:0]      map_width_r;
  logic [CFG_DIM_W-1:0]      map_height_r;
  logic signed [THR_W-1:0]   thr_r;
  logic [STEP_W-1:0]         grid_step_r;
  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;
  logic [SIZE_W-1:0]         cell_size_r;

  // sequencer and counters
  fetch_state_t      state_r, state_nxt;
  logic [COL_W-1:0]  col_r;
  logic [ROWC_W-1:0] row_r;
  logic [STEP_W-1:0] gcp_r;
  logic [STEP_W-1:0] grp_r;

  // line buffer, read register and bypass
  free_pair_t        lbuf [MAX_WIDTH];
  free_pair_t        rd_r;
  logic              byp_r;
  free_pair_t        byp_word_r;
  free_pair_t        head;
  logic              rd_en;
  logic [COL_W-1:0]  raddr;
  logic              byp_set;

  // window cells
  cell_ctrl_t        ctrl_c, ctrl_l;
  free_pair_t        cell_c_q, cell_l_q;

  // decision path
  logic              width_wr;
  logic              in_acc;
  logic              out_acc;
  logic signed [VALUE_W-1:0] cell_value;
  logic              pad_row;
  logic [DIM_W-1:0]  w_eff;
  logic [ROWC_W-1:0] h_eff;
  logic [STEP_W-1:0] step_eff;
  logic [DIM_W-1:0]  c_ext, c_inc, n1, n1_inc, n2;
  logic              last;
  logic              cur_free;
  logic              old_c;
  logic              row_decided;
  logic              row_pad;
  logic              nb;
  logic              on_grid;
  logic              keep;
  logic              done;
  logic [ROWC_W-1:0] dr;
  free_pair_t        wr_word;

  // result pipeline
  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic                 s1_keep_r, s2_keep_r, s3_keep_r;
  logic                 s1_done_r, s2_done_r, s3_done_r;
  logic                 s1_dec_r;
  logic [COL_W-1:0]     s1_col_r, s2_col_r, s3_col_r;
  logic [ROW_W-1:0]     s1_row_r, s2_row_r, s3_row_r;
  logic signed [COORD_W-1:0] point_x, point_y;

  // result queue
  result_t                fifo_r [FIFO_DEPTH];
  result_t                entry;
  result_t                fifo_head;
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  cnt_r;
  logic [FIFO_CNT_W-1:0]  outst_r;

  // lattice phase step, wrapping at the grid step
  function automatic logic [STEP_W-1:0] phase_next(input logic [STEP_W-1:0] p,
                                                   input logic [STEP_W-1:0] s);
    logic [STEP_W:0] p_inc;
    p_inc = {1'b0, p} + 1'b1;
    return (p_inc >= {1'b0, s}) ? '0 : p_inc[STEP_W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= RST_MAP_WIDTH;
      map_height_r <= RST_MAP_HEIGHT;
      thr_r        <= RST_THRESHOLD;
      grid_step_r  <= RST_GRID_STEP;
      origin_x_r   <= RST_ORIGIN;
      origin_y_r   <= RST_ORIGIN;
      cell_size_r  <= RST_CELL_SIZE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_MAP_WIDTH:      map_width_r  <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_MAP_HEIGHT:     map_height_r <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_OBST_THRESHOLD: thr_r        <= cfg_wdata[THR_W-1:0];
        CFG_GRID_STEP:      grid_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_ORIGIN_X:       origin_x_r   <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Y:       origin_y_r   <= cfg_wdata[COORD_W-1:0];
        CFG_CELL_SIZE:      cell_size_r  <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign width_wr  = cfg_wr_en && (cfg_addr == CFG_MAP_WIDTH);
  assign in_tready = (state_r == ST_RUN) && (outst_r < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // effective dimensions and step
  always_comb begin
    if (map_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(map_width_r) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(map_width_r);
    end
    if (map_height_r == '0) begin
      h_eff = ROWC_W'(1);
    end else if (32'(map_height_r) > MAX_HEIGHT) begin
      h_eff = ROWC_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROWC_W'(map_height_r);
    end
    step_eff = (grid_step_r == '0) ? STEP_W'(1) : grid_step_r;
  end

  // next two columns in stream order
  always_comb begin
    c_ext  = {1'b0, col_r};
    c_inc  = c_ext + 1'b1;
    last   = (c_inc >= w_eff);
    n1     = last ? '0 : c_inc;
    n1_inc = n1 + 1'b1;
    n2     = (n1_inc >= w_eff) ? '0 : n1_inc;
  end

  // right neighbor comes from the read register or from a same-cycle write
  assign head = byp_r ? byp_word_r : rd_r;

  // cell classification and keep decision
  assign cell_value = in_tdata[VALUE_W-1:0];
  assign pad_row    = in_tuser;

  always_comb begin
    cur_free    = !pad_row && !cell_value[VALUE_W-1] && (cell_value <= thr_r);
    old_c       = cell_c_q.center;
    row_decided = (row_r != '0);
    row_pad     = (row_r >= h_eff);
    nb          = (!last && head.center) ||
                  ((col_r != '0) && cell_l_q.center) ||
                  ((row_r >= ROWC_W'(2)) && cell_c_q.upper) ||
                  (!row_pad && cur_free);
    on_grid     = (gcp_r == '0) && (grp_r == '0);
    keep        = row_decided && !old_c && (nb || on_grid);
    done        = row_pad && last;
    dr          = row_r - 1'b1;
    wr_word     = '{upper: old_c, center: cur_free};
  end

  // sequencer: window refill after reset and width change, then streaming
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FETCH_A;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    raddr     = col_r;
    ctrl_c    = '{en: 1'b0, load_ext: 1'b0};
    ctrl_l    = '{en: in_acc, load_ext: 1'b0};
    case (state_r)
      ST_FETCH_A: begin
        rd_en     = 1'b1;
        raddr     = col_r;
        state_nxt = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        rd_en     = 1'b1;
        raddr     = n1[COL_W-1:0];
        ctrl_c    = '{en: 1'b1, load_ext: 1'b0};
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        rd_en  = in_acc;
        raddr  = n2[COL_W-1:0];
        ctrl_c = '{en: in_acc, load_ext: (n1 == c_ext)};
      end
      default: state_nxt = ST_FETCH_A;
    endcase
    if (width_wr) begin
      state_nxt = ST_FETCH_A;
    end
  end

  // column, row and lattice phase counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      gcp_r <= '0;
      grp_r <= '0;
    end else if (in_acc) begin
      if (last) begin
        col_r <= '0;
        gcp_r <= '0;
        if (row_pad) begin
          row_r <= '0;
          grp_r <= '0;
        end else begin
          if (row_decided) begin
            grp_r <= phase_next(grp_r, step_eff);
          end
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= c_inc[COL_W-1:0];
        gcp_r <= phase_next(gcp_r, step_eff);
      end
    end
  end

  // line buffer: one write and one registered read per cycle, written only on an accepted cell
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lbuf[col_r] <= wr_word;
    end
    if (rd_en) begin
      rd_r <= lbuf[raddr];
    end
  end

  // bypass when the prefetched column is the one written now
  assign byp_set = in_acc && (n2 == c_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= byp_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_word_r <= wr_word;
    end
  end

  // window: decided column, then its left neighbor
  obpe_cell u_cell_c (
    .clk      (clk),
    .ctrl     (ctrl_c),
    .ext_word (wr_word),
    .nbr_word (head),
    .word     (cell_c_q)
  );

  obpe_cell u_cell_l (
    .clk      (clk),
    .ctrl     (ctrl_l),
    .ext_word (cell_c_q),
    .nbr_word (cell_c_q),
    .word     (cell_l_q)
  );

  // result pipeline valid tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // result pipeline payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_keep_r <= keep;
      s1_done_r <= done;
      s1_dec_r  <= row_decided;
      s1_col_r  <= row_decided ? col_r : '0;
      s1_row_r  <= row_decided ? dr[ROW_W-1:0] : '0;
    end
    s2_keep_r <= s1_keep_r;
    s2_done_r <= s1_done_r;
    s2_col_r  <= s1_col_r;
    s2_row_r  <= s1_row_r;
    s3_keep_r <= s2_keep_r;
    s3_done_r <= s2_done_r;
    s3_col_r  <= s2_col_r;
    s3_row_r  <= s2_row_r;
  end

  // coordinates, aligned with the third stage
  obpe_coord u_coord_x (
    .clk       (clk),
    .idx       (IDX_W'(s1_col_r)),
    .zero      (!s1_dec_r),
    .origin    (origin_x_r),
    .cell_size (cell_size_r),
    .point     (point_x)
  );

  obpe_coord u_coord_y (
    .clk       (clk),
    .idx       (IDX_W'(s1_row_r)),
    .zero      (!s1_dec_r),
    .origin    (origin_y_r),
    .cell_size (cell_size_r),
    .point     (point_y)
  );

  // result queue entry
  always_comb begin
    entry.keep = s3_keep_r;
    entry.done = s3_done_r;
    entry.col  = OUT_IDX_W'(s3_col_r);
    entry.row  = OUT_IDX_W'(s3_row_r);
    entry.x    = point_x;
    entry.y    = point_y;
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      fifo_r[wr_ptr_r] <= entry;
    end
  end

  // queue pointers, fill and credit counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      outst_r  <= '0;
    end else begin
      if (s3_v_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r   <= cnt_r + FIFO_CNT_W'(s3_v_r) - FIFO_CNT_W'(out_acc);
      outst_r <= outst_r + FIFO_CNT_W'(in_acc) - FIFO_CNT_W'(out_acc);
    end
  end

  // output transaction
  assign fifo_head  = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = OUT_TDATA_W'({fifo_head.y, fifo_head.x, fifo_head.row, fifo_head.col});
  assign out_tuser  = fifo_head.keep;
  assign out_tlast  = fifo_head.done;

endmodule

[hdl/obpe_checker.sv]
`timescale 1ns / 1ps
// checker on the ports of the boundary point extractor, bound to the top level
module obpe_checker import obpe_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast,
  input logic                   cfg_wr_en,
  input logic [CFG_ADDR_W-1:0]  cfg_addr
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the queue and starts the window refill
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("not idle after reset");

  // a width write keeps in_tready low while the window refills
  a_width_refill: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_addr == CFG_MAP_WIDTH) |=> !in_tready ##1 !in_tready)
    else $error("input taken during window refill");

  // the queue only fills from a taken cell, passed through the s1, s2 and s3 registers
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 4))
    else $error("result without matching input transaction");

endmodule

bind occupancy_boundary_point_extract_core obpe_checker u_obpe_checker (.*);
